FILE: rtl/bisf_pkg.sv
package bisf_pkg;

  // width of the one configuration register
  localparam int CFG_BITS = 13;

  // full byte of pixels
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  // reset value of the image width register
  localparam logic [CFG_BITS-1:0] WIDTH_RESET = 13'd4096;

  // rows of the current image seen so far, saturating at two
  localparam logic [1:0] ROWS_FULL = 2'd2;

  // item held in the compute stage
  typedef struct packed {
    logic [7:0] low;       // incoming byte, tail bits cleared
    logic [7:0] tail_mask; // valid pixel bits of the last byte of a row
    logic       last;      // byte is the last of its row
    logic       first;     // byte starts a new image
    logic [1:0] rows;      // complete rows of this image before this byte
    logic       col_zero;  // byte is the first of its row
  } s1_item_t;

  // 3x3 smoothing on a 24-pixel window of three rows, bit 23 leftmost
  function automatic logic [23:0] smooth24(input logic [23:0] u, input logic [23:0] t,
                                           input logic [23:0] d);
    logic [23:0] l, r, ul, ur, dl, dr, four, two, one;
    l    = t >> 1;
    r    = t << 1;
    ul   = u >> 1;
    ur   = u << 1;
    dl   = d >> 1;
    dr   = d << 1;
    four = l & r & u & d;
    two  = (l & u) | (u & r) | (r & d) | (l & d) | (l & r) | (u & d);
    one  = ((u | d) & ((ul & dl) | (ur & dr))) | ((l | r) & ((ul & ur) | (dl & dr)));
    return four | (t & (two | one));
  endfunction

endpackage

FILE: rtl/binary_image_smoothing_filter.sv
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   tdata[7:0] pixels, tuser first_of_image
// m_*       out        m_tvalid/m_tready   tdata[7:0] smoothed, tlast row_end,
//                                          tuser last_of_run
// cfg_*     in         cfg_wr_en           cfg_wr_data[12:0] width_pixels
//
// One input byte per cycle unless the compute stage is held. From the second row
// of an image on, the last byte of a row wider than one byte gives two results
// and holds the compute stage until both are taken, since the output register
// takes one result per cycle. A byte's results pass the compute stage and then
// the output register on their way to m_*; its second result follows its first.
// The two row stores are memories with a registered read, read on the input
// transfer and written back when the compute stage retires its byte; a write and
// a read of the same column in one cycle are forwarded.
// Reset (rst, synchronous) empties the pipeline, the column and row counts and
// the window history; the row stores hold undefined data until written.
// A stalled output holds the compute stage, which in turn holds the input.
module binary_image_smoothing_filter
  import bisf_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,     // [7:0] pixels
  input  logic                s_tuser,     // [0] first_of_image
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,     // [7:0] smoothed
  output logic                m_tlast,     // row_end
  output logic                m_tuser,     // [0] last_of_run
  input  logic                cfg_wr_en,
  input  logic [CFG_BITS-1:0] cfg_wr_data  // width_pixels
);

  localparam int ROW_BYTES = (MAX_WIDTH + 7) / 8;
  localparam int AW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam logic [CFG_BITS-1:0] WMAX =
    (MAX_WIDTH > 8191) ? 13'd8191 : CFG_BITS'(MAX_WIDTH);

  // configuration
  logic [CFG_BITS-1:0] width_pixels;

  // row stores
  logic [7:0] upper_mem [ROW_BYTES];
  logic [7:0] middle_mem [ROW_BYTES];
  logic [7:0] upper_rd, middle_rd;
  logic       fwd;
  logic [7:0] fwd_upper, fwd_middle;

  // input side control
  logic [AW-1:0] col_idx, col_idx_next;
  logic [1:0]    rows_rcv, rows_rcv_next;

  // stage 0 decode
  logic [CFG_BITS-1:0] w_clamp;
  logic [AW-1:0]       last_col, col_base, col0;
  logic [1:0]          rows_base;
  logic                is_last;
  logic [7:0]          tail_mask;
  logic                in_fire;

  // compute stage
  logic          s1_valid;
  s1_item_t      s1;
  logic [AW-1:0] s1_col;
  logic          s1_phase;
  logic [15:0]   hist0, hist1, hist2;
  logic [15:0]   h0, h1, h2;
  logic [7:0]    up_b, mid_b;
  logic [23:0]   wu, wm, wd;
  logic [23:0]   sm0, sm1;
  logic          has0, has1, cur_is0, cur_exists, cur_final;
  logic          out_free, push, s1_done;

  // width register
  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels <= WIDTH_RESET;
    end else if (cfg_wr_en) begin
      width_pixels <= cfg_wr_data;
    end
  end

  // width clamp, last column and tail mask
  always_comb begin
    if (width_pixels == '0) begin
      w_clamp = CFG_BITS'(1);
    end else if (width_pixels > WMAX) begin
      w_clamp = WMAX;
    end else begin
      w_clamp = width_pixels;
    end
    last_col = AW'((w_clamp - CFG_BITS'(1)) >> 3);
    if (w_clamp[2:0] == 3'd0) begin
      tail_mask = BYTE_ONES;
    end else begin
      tail_mask = BYTE_ONES << (4'd8 - {1'b0, w_clamp[2:0]});
    end
  end

  // column of the incoming byte
  always_comb begin
    col_base  = s_tuser ? '0 : col_idx;
    rows_base = s_tuser ? 2'd0 : rows_rcv;
    col0      = (col_base > last_col) ? last_col : col_base;
    is_last   = (col0 == last_col);
    if (is_last) begin
      col_idx_next  = '0;
      rows_rcv_next = (rows_base == ROWS_FULL) ? rows_base : rows_base + 2'd1;
    end else begin
      col_idx_next  = col0 + AW'(1);
      rows_rcv_next = rows_base;
    end
  end

  assign s_tready = !s1_valid || s1_done;
  assign in_fire  = s_tvalid && s_tready;

  // column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx  <= '0;
      rows_rcv <= 2'd0;
    end else if (in_fire) begin
      col_idx  <= col_idx_next;
      rows_rcv <= rows_rcv_next;
    end
  end

  // row store write-back when the compute stage retires its byte
  always_ff @(posedge clk) begin
    if (s1_done) begin
      upper_mem[s1_col]  <= mid_b;
      middle_mem[s1_col] <= s1.low;
    end
  end

  // row store read on the input transfer, with forwarding of a same-column write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      upper_rd   <= upper_mem[col0];
      middle_rd  <= middle_mem[col0];
      fwd        <= s1_done && (s1_col == col0);
      fwd_upper  <= mid_b;
      fwd_middle <= s1.low;
    end
  end

  // compute stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1.low       <= is_last ? (s_tdata & tail_mask) : s_tdata;
      s1.tail_mask <= tail_mask;
      s1.last      <= is_last;
      s1.first     <= s_tuser;
      s1.rows      <= rows_base;
      s1.col_zero  <= (col0 == '0);
      s1_col       <= col0;
    end
  end

  // window assembly and smoothing
  always_comb begin
    up_b  = (s1.rows >= ROWS_FULL) ? (fwd ? fwd_upper : upper_rd) : 8'd0;
    mid_b = (s1.rows != 2'd0) ? (fwd ? fwd_middle : middle_rd) : 8'd0;
    h0    = s1.first ? 16'd0 : hist0;
    h1    = s1.first ? 16'd0 : hist1;
    h2    = s1.first ? 16'd0 : hist2;
    wu    = {h0, up_b};
    wm    = {h1, mid_b};
    wd    = {h2, s1.low};
    sm0   = smooth24(wu, wm, wd);
    sm1   = smooth24({wu[15:0], 8'd0}, {wm[15:0], 8'd0}, {wd[15:0], 8'd0});
  end

  // result sequencing
  always_comb begin
    has0       = (s1.rows != 2'd0) && !s1.col_zero;
    has1       = (s1.rows != 2'd0) && s1.last;
    cur_is0    = !s1_phase && has0;
    cur_exists = cur_is0 || has1;
    cur_final  = !(cur_is0 && has1);
    out_free   = !m_tvalid || m_tready;
    push       = s1_valid && cur_exists && out_free;
    s1_done    = s1_valid && (!cur_exists || (push && cur_final));
  end

  // compute stage control and window history
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
      hist0    <= 16'd0;
      hist1    <= 16'd0;
      hist2    <= 16'd0;
    end else begin
      if (s1_done) begin
        s1_phase <= 1'b0;
      end else if (push && !cur_final) begin
        s1_phase <= 1'b1;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        if (s1.last) begin
          hist0 <= 16'd0;
          hist1 <= 16'd0;
          hist2 <= 16'd0;
        end else begin
          hist0 <= wu[15:0];
          hist1 <= wm[15:0];
          hist2 <= wd[15:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= cur_is0 ? sm0[15:8] : (sm1[15:8] & s1.tail_mask);
      m_tlast <= !cur_is0;
      m_tuser <= cur_final;
    end
  end

`ifndef ASSERT_OFF
  // the second result of a byte is only pending while that byte is held
  a_phase_held: assert property (@(posedge clk) disable iff (rst) s1_phase |-> s1_valid)
    else $error("result phase set with empty compute stage");

  // a row end is always the final result of its input byte
  a_row_end_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("row end not marked as final result");

  // row count saturates at two
  a_rows_sat: assert property (@(posedge clk) disable iff (rst) rows_rcv != 2'd3)
    else $error("row count past saturation");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> (!s1_valid && !m_tvalid))
    else $error("pipeline not empty after reset");
`endif

endmodule

FILE: sim/binary_image_smoothing_filter_tb.sv
`timescale 1ns / 100ps

module binary_image_smoothing_filter_tb;
  import bisf_pkg::*;

  localparam int MAX_PIX    = 4096;
  localparam int ROW_BYTES  = (MAX_PIX + 7) / 8;
  localparam int RANDOM_BYTES = 1150;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD  = 400;
  localparam int HOLD_AFTER = 30;

  typedef enum logic {STEP_BYTE, STEP_WIDTH} step_kind_t;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_SPARSE, FILL_DENSE, FILL_BLOCKY} fill_t;

  // one line of the directed plan; want is used only when typed is set
  typedef struct packed {
    step_kind_t          kind;
    logic [CFG_BITS-1:0] width;
    logic [7:0]          pixels;
    logic                first;
    logic                typed;
    logic [7:0]          want;
  } plan_row_t;

  typedef struct packed {
    logic [7:0] smoothed;
    logic       row_end;
    logic       last_of_run;
  } smooth_out_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;   // [7:0] pixels
  logic                s_tuser;   // [0] first_of_image
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;   // [7:0] smoothed
  logic                m_tlast;   // row_end
  logic                m_tuser;   // [0] last_of_run
  logic                cfg_wr_en;
  logic [CFG_BITS-1:0] cfg_wr_data;

  // shadow of the filter state
  logic [CFG_BITS-1:0] width_reg;
  logic [7:0]          upper_mem [ROW_BYTES];
  logic [7:0]          middle_mem [ROW_BYTES];
  logic [15:0]         hist_bits [3];
  int unsigned         col_ptr;
  int unsigned         rows_done;

  smooth_out_t smoothed_due[$];
  int          failures;
  int          results_seen;
  int unsigned bytes_sent;
  bit          quiet;

  // directed plan: extremes of width, tail masking, restarts, column clamp
  plan_row_t plan [30] = '{
    // full width after reset, first row only, then width above the maximum
    '{STEP_BYTE,  13'd0,    8'hFF, 1'b1, 1'b0, 8'h00},
    '{STEP_WIDTH, 13'h1FFF, 8'h00, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h5A, 1'b1, 1'b0, 8'h00},
    // width zero acts as one pixel: a pixel survives only between two black rows
    '{STEP_WIDTH, 13'd0,    8'h00, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'hFF, 1'b1, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h7F, 1'b0, 1'b1, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h80, 1'b0, 1'b1, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h80, 1'b0, 1'b1, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h80, 1'b0, 1'b1, 8'h80},
    '{STEP_BYTE,  13'd0,    8'h00, 1'b0, 1'b1, 8'h00},
    // three pixels: hollow ring fills in, stray bits past the width ignored
    '{STEP_WIDTH, 13'd3,    8'h00, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'hFF, 1'b1, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'hA3, 1'b0, 1'b1, 8'hE0},
    '{STEP_BYTE,  13'd0,    8'hFF, 1'b0, 1'b1, 8'hE0},
    '{STEP_BYTE,  13'd0,    8'h00, 1'b0, 1'b1, 8'hE0},
    // two bytes per row, then a restart in the middle of a row
    '{STEP_WIDTH, 13'd16,   8'h00, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h81, 1'b1, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h7E, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h3C, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'hC3, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h18, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h66, 1'b1, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h99, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h24, 1'b0, 1'b0, 8'h00},
    // shrink mid-row: column is past the new row end and clamps
    '{STEP_WIDTH, 13'd8,    8'h00, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h5A, 1'b0, 1'b0, 8'h00},
    // single edge neighbour bridged by a diagonal pair
    '{STEP_BYTE,  13'd0,    8'hC0, 1'b1, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h40, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h80, 1'b0, 1'b0, 8'h00},
    '{STEP_BYTE,  13'd0,    8'h00, 1'b0, 1'b0, 8'h00}
  };

  logic [CFG_BITS-1:0] corner_widths [8] = '{13'd0, 13'd1, 13'd2, 13'd7, 13'd8, 13'd9,
                                              13'd15, 13'd17};

  binary_image_smoothing_filter #(.MAX_WIDTH(MAX_PIX)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("binary_image_smoothing_filter_tb: done, errors");
    $finish;
  end

  // width as the filter uses it
  function automatic int unsigned eff_width(logic [CFG_BITS-1:0] w);
    if (w < 1) return 1;
    if (w > MAX_PIX) return MAX_PIX;
    return w;
  endfunction

  // valid pixel bits of the last byte of a row
  function automatic logic [7:0] tail_bits(int unsigned eff);
    if (eff % 8 != 0) return 8'(BYTE_ONES << (8 - eff % 8));
    return BYTE_ONES;
  endfunction

  // smoothed pixels of the middle byte of a three-row, three-byte window
  function automatic logic [7:0] smooth_window(logic [23:0] u, logic [23:0] t,
                                               logic [23:0] d);
    logic [7:0] res;
    logic lf, rt, up, dn, ul, ur, dl, dr;
    int edges;
    for (int i = 8; i < 16; i++) begin
      lf = t[i+1];
      rt = t[i-1];
      up = u[i];
      dn = d[i];
      ul = u[i+1];
      ur = u[i-1];
      dl = d[i+1];
      dr = d[i-1];
      edges = int'(lf) + int'(rt) + int'(up) + int'(dn);
      if (edges == 4) begin
        res[i-8] = 1'b1;
      end else if (!t[i] || edges == 0) begin
        res[i-8] = 1'b0;
      end else if (edges >= 2) begin
        res[i-8] = 1'b1;
      end else begin
        // lone neighbour: keep only if a diagonal pair bridges it
        res[i-8] = ((up | dn) & ((ul & dl) | (ur & dr))) |
                   ((lf | rt) & ((ul & ur) | (dl & dr)));
      end
    end
    return res;
  endfunction

  // advance the shadow state by one accepted byte and queue its results
  function automatic void predict_byte(logic [7:0] pixels, logic first);
    int unsigned eff, nb, c;
    logic [7:0] tail, low, up, mid;
    logic [23:0] wu, wm, wd;
    logic lastb;
    eff  = eff_width(width_reg);
    nb   = (eff + 7) / 8;
    tail = tail_bits(eff);
    if (first) begin
      col_ptr   = 0;
      rows_done = 0;
      hist_bits = '{default: '0};
    end
    c     = (col_ptr > nb - 1) ? nb - 1 : col_ptr;
    lastb = (c == nb - 1);
    low   = lastb ? (pixels & tail) : pixels;
    up    = (rows_done >= 2) ? upper_mem[c] : 8'h00;
    mid   = (rows_done >= 1) ? middle_mem[c] : 8'h00;
    wu    = {hist_bits[0], up};
    wm    = {hist_bits[1], mid};
    wd    = {hist_bits[2], low};
    if (rows_done >= 1) begin
      if (c >= 1)
        smoothed_due.push_back('{smoothed: smooth_window(wu, wm, wd), row_end: 1'b0,
                                 last_of_run: !lastb});
      if (lastb)
        smoothed_due.push_back('{smoothed: smooth_window(wu << 8, wm << 8, wd << 8) & tail,
                                 row_end: 1'b1, last_of_run: 1'b1});
    end
    upper_mem[c]  = mid;
    middle_mem[c] = low;
    if (lastb) begin
      hist_bits = '{default: '0};
      col_ptr   = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      hist_bits[0] = wu[15:0];
      hist_bits[1] = wm[15:0];
      hist_bits[2] = wd[15:0];
      col_ptr      = c + 1;
    end
  endfunction

  function automatic logic [7:0] draw_byte(fill_t mode);
    case (mode)
      FILL_SPARSE: return 8'($urandom) & 8'($urandom);
      FILL_DENSE:  return 8'($urandom) | 8'($urandom);
      FILL_BLOCKY: return ($urandom_range(0, 1) ? BYTE_ONES : 8'h00) ^
                          (8'($urandom) & 8'($urandom) & 8'($urandom));
      default:     return 8'($urandom);
    endcase
  endfunction

  // offer one byte after a random gap and wait for its transfer
  task automatic feed_byte(logic [7:0] pixels, logic first, logic typed = 1'b0,
                           logic [7:0] want = 8'h00);
    int unsigned gap;
    smooth_out_t last_res;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pixels;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(pixels, first);
    // hand-worked value replaces the predicted pixels
    if (typed && smoothed_due.size() != 0) begin
      last_res = smoothed_due.pop_back();
      last_res.smoothed = want;
      smoothed_due.push_back(last_res);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // width write once the filter has gone idle
  task automatic set_width(logic [CFG_BITS-1:0] w);
    s_tvalid <= 1'b0;
    while (smoothed_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    width_reg   = w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one image of random rows, usually closed by an all-zero flush row
  task automatic send_image(int unsigned eff, bit start_new);
    int unsigned nb, rows, cut_row, cut_col;
    logic [7:0] tail, b;
    fill_t mode;
    bit broken, flush;
    nb      = (eff + 7) / 8;
    tail    = tail_bits(eff);
    rows    = $urandom_range(1, 5);
    mode    = fill_t'($urandom_range(0, 3));
    broken  = ($urandom_range(0, 9) == 0);
    flush   = ($urandom_range(0, 9) != 0);
    cut_row = $urandom_range(0, rows);
    cut_col = $urandom_range(0, nb - 1);
    for (int r = 0; r <= rows; r++) begin
      if (r == rows && !flush) break;
      for (int c = 0; c < nb; c++) begin
        b = (r == rows) ? 8'h00 : draw_byte(mode);
        if (c == nb - 1 && $urandom_range(0, 9) < 7) b &= tail;
        feed_byte(b, start_new && r == 0 && c == 0);
        if (broken && r == cut_row && c == cut_col) return;
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    smooth_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (smoothed_due.size() == 0) begin
        $error("unexpected result: smoothed %h row_end %b last_of_run %b",
               m_tdata, m_tlast, m_tuser);
        failures++;
      end else begin
        want = smoothed_due.pop_front();
        if (m_tdata !== want.smoothed) begin
          $error("smoothed: expected %h, got %h", want.smoothed, m_tdata);
          failures++;
        end
        if (m_tlast !== want.row_end) begin
          $error("row_end: expected %b, got %b", want.row_end, m_tlast);
          failures++;
        end
        if (m_tuser !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, m_tuser);
          failures++;
        end
      end
    end
  end

  // receiver: random stalls per result, one long hold-off to back up the input
  initial begin
    int unsigned wait_cycles;
    bit held;
    m_tready = 1'b0;
    held = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      wait_cycles = quiet ? 0 : $urandom_range(0, 7);
      if (wait_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned random_start, eff, prev_eff, images, settle;
    logic [CFG_BITS-1:0] w;
    bit keep;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tuser      = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    quiet        = 1'b0;
    failures     = 0;
    results_seen = 0;
    bytes_sent   = 0;
    width_reg    = WIDTH_RESET;
    col_ptr      = 0;
    rows_done    = 0;
    hist_bits    = '{default: '0};
    foreach (upper_mem[i]) begin
      upper_mem[i]  = 8'h00;
      middle_mem[i] = 8'h00;
    end
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WIDTH)
        set_width(plan[i].width);
      else
        feed_byte(plan[i].pixels, plan[i].first, plan[i].typed, plan[i].want);
    end

    // full-width image: one whole row and the start of the next
    random_start = bytes_sent;
    set_width(13'h1FFF);
    for (int i = 0; i < ROW_BYTES + 40; i++)
      feed_byte(draw_byte(fill_t'($urandom_range(0, 3))), i == 0);
    prev_eff = MAX_PIX;

    // random widths; a width no wider than the last may carry on the image in progress
    while (bytes_sent < random_start + RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0:       w = corner_widths[$urandom_range(0, 7)];
        1, 2:    w = CFG_BITS'($urandom_range(25, 200));
        default: w = CFG_BITS'($urandom_range(1, 24));
      endcase
      eff  = eff_width(w);
      keep = (eff <= prev_eff) && ($urandom_range(0, 3) == 0);
      set_width(w);
      quiet  = ($urandom_range(0, 3) == 0);
      images = $urandom_range(1, 3);
      for (int k = 0; k < images; k++)
        send_image(eff, !(keep && k == 0));
      prev_eff = eff;
    end

    // drain
    s_tvalid <= 1'b0;
    settle = 0;
    while (smoothed_due.size() != 0 && settle < 5000) begin
      @(negedge clk);
      settle++;
    end
    repeat (16) @(negedge clk);
    if (smoothed_due.size() != 0) begin
      $error("%0d expected results never arrived", smoothed_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("binary_image_smoothing_filter_tb: done, clean");
    end else begin
      $display("binary_image_smoothing_filter_tb: done, errors");
    end
    $finish;
  end

endmodule
